>>> sv/sem_pkg.sv
`default_nettype none

package sem_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned RESET_WIDTH    = 640;
  localparam int unsigned RESET_HEIGHT   = 480;
  localparam logic [7:0]  MAG_CAP        = 8'd255;
  localparam logic [20:0] MAG_CAP_SQ     = 21'd65280;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [23:0] pix_t;
  // row 0 top, row 2 bottom
  typedef pix_t [2:0] col_t;
  // column 0 left, column 2 right
  typedef col_t [2:0] win_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SQ,
    M_SUM,
    M_ROOT,
    M_ROUND
  } mag_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_PXRD,
    T_DRRD,
    T_MAG,
    T_OUT
  } top_state_t;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned m);
    if (v == 0) return 1;
    if (v > m) return m;
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/sem_mag.sv
`default_nettype none

module sem_mag (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire sem_pkg::win_t      win,
  output logic                    done,
  output logic [2:0][7:0]         mag
);

  sem_pkg::mag_state_t state_r, state_nxt;
  logic [2:0]        bit_r;
  logic              done_r;
  logic [2:0][9:0]   ax_r, ay_r;
  logic [2:0][19:0]  sqx_r, sqy_r;
  logic [2:0][20:0]  s_r;
  logic [2:0][7:0]   q_r;
  logic [2:0][7:0]   mag_r;
  logic [2:0][9:0]   ax_c, ay_c;
  logic [2:0][7:0]   t_c;
  logic [2:0][15:0]  tt_c;
  logic [2:0][15:0]  qq_c;

  always_comb begin
    logic [9:0] xr, xl, yb, yt;
    for (int ch = 0; ch < 3; ch++) begin
      xr = {2'b0, win[2][0][8*ch +: 8]} + {1'b0, win[2][1][8*ch +: 8], 1'b0}
         + {2'b0, win[2][2][8*ch +: 8]};
      xl = {2'b0, win[0][0][8*ch +: 8]} + {1'b0, win[0][1][8*ch +: 8], 1'b0}
         + {2'b0, win[0][2][8*ch +: 8]};
      yb = {2'b0, win[0][2][8*ch +: 8]} + {1'b0, win[1][2][8*ch +: 8], 1'b0}
         + {2'b0, win[2][2][8*ch +: 8]};
      yt = {2'b0, win[0][0][8*ch +: 8]} + {1'b0, win[1][0][8*ch +: 8], 1'b0}
         + {2'b0, win[2][0][8*ch +: 8]};
      ax_c[ch] = (xr >= xl) ? xr - xl : xl - xr;
      ay_c[ch] = (yb >= yt) ? yb - yt : yt - yb;
      t_c[ch]  = q_r[ch] | (8'd1 << bit_r);
      tt_c[ch] = t_c[ch] * t_c[ch];
      qq_c[ch] = q_r[ch] * q_r[ch];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sem_pkg::M_IDLE:  if (start) state_nxt = sem_pkg::M_SQ;
      sem_pkg::M_SQ:    state_nxt = sem_pkg::M_SUM;
      sem_pkg::M_SUM:   state_nxt = sem_pkg::M_ROOT;
      sem_pkg::M_ROOT:  if (bit_r == 3'd0) state_nxt = sem_pkg::M_ROUND;
      sem_pkg::M_ROUND: state_nxt = sem_pkg::M_IDLE;
      default:          state_nxt = sem_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sem_pkg::M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == sem_pkg::M_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      sem_pkg::M_IDLE: begin
        ax_r <= ax_c;
        ay_r <= ay_c;
      end
      sem_pkg::M_SQ: begin
        for (int ch = 0; ch < 3; ch++) begin
          sqx_r[ch] <= ax_r[ch] * ax_r[ch];
          sqy_r[ch] <= ay_r[ch] * ay_r[ch];
        end
      end
      sem_pkg::M_SUM: begin
        for (int ch = 0; ch < 3; ch++) begin
          s_r[ch] <= {1'b0, sqx_r[ch]} + {1'b0, sqy_r[ch]};
          q_r[ch] <= 8'd0;
        end
        bit_r <= 3'd7;
      end
      sem_pkg::M_ROOT: begin
        for (int ch = 0; ch < 3; ch++) begin
          if ({5'b0, tt_c[ch]} <= s_r[ch]) q_r[ch] <= t_c[ch];
        end
        bit_r <= bit_r - 3'd1;
      end
      sem_pkg::M_ROUND: begin
        for (int ch = 0; ch < 3; ch++) begin
          if (s_r[ch] > sem_pkg::MAG_CAP_SQ) begin
            mag_r[ch] <= sem_pkg::MAG_CAP;
          end else if ((s_r[ch][15:0] - qq_c[ch]) > {8'd0, q_r[ch]}) begin
            mag_r[ch] <= q_r[ch] + 8'd1;
          end else begin
            mag_r[ch] <= q_r[ch];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign mag  = mag_r;

endmodule

`default_nettype wire

>>> sv/sobel_edge_magnitude_rgb_top.sv
`default_nettype none

// 3x3 Sobel edge magnitude per RGB channel on a raster pixel stream, zero
// outside the frame. Two line memories hold the rows above; each pixel beat
// reads its column from both in one cycle and writes it back the next. A pixel
// beat yields 0, 1 or 2 results and a drain beat one result; each result
// comes from the 8-step bit-serial rounded square root in the magnitude
// unit and waits until the output register is free. Results are held in an
// output register, so the next beat is taken while one waits.

module sobel_edge_magnitude_rgb_top #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_pixel_red,
  input  wire logic [7:0]  in_pixel_green,
  input  wire logic [7:0]  in_pixel_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_edge_red,
  output logic [7:0]       out_edge_green,
  output logic [7:0]       out_edge_blue,
  output logic [11:0]      out_row,
  output logic [9:0]       out_col,
  output logic             out_last_in_run,
  output logic             out_end_of_frame
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HCW = $clog2(MAX_HEIGHT + 1);

  sem_pkg::top_state_t state_r, state_nxt;

  logic [WCW-1:0] eff_w_r;
  logic [HCW-1:0] eff_h_r;
  logic [AW-1:0]  c_r, d_r;
  logic [RW-1:0]  r_r;
  logic           draining_r;
  logic [1:0]     dk_r;
  logic           rvld_r;
  logic           jobb_r;
  logic           start_r;
  sem_pkg::col_t [1:0] wc_r;
  sem_pkg::win_t  g_r;
  sem_pkg::pix_t  px_r;
  logic [11:0]    res_row_r;
  logic [9:0]     res_col_r;
  logic           res_last_r, res_eof_r;

  logic           out_valid_r;
  logic [2:0][7:0] out_mag_r;
  logic [11:0]    out_row_r;
  logic [9:0]     out_col_r;
  logic           out_last_r, out_eof_r;

  sem_pkg::pix_t  mem_one [MAX_WIDTH];
  sem_pkg::pix_t  mem_two [MAX_WIDTH];
  sem_pkg::pix_t  rd_one_r, rd_two_r;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;

  logic           mag_done;
  logic [2:0][7:0] mag;

  logic           accept, out_load;
  logic           r_ge1, r_ge2, c_ge1, h_ge2, end_row, last_row, job_a, job_b;
  logic           d_end, dn2_vld;
  sem_pkg::pix_t  top_px, mid_px;
  sem_pkg::col_t  new_col;

  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == sem_pkg::T_OUT) && (!out_valid_r || out_ready);

  assign r_ge1    = (r_r != '0);
  assign r_ge2    = (32'(r_r) >= 32'd2);
  assign c_ge1    = (c_r != '0);
  assign h_ge2    = (32'(eff_h_r) >= 32'd2);
  assign end_row  = ((WCW'(c_r) + WCW'(1)) >= eff_w_r);
  assign last_row = ((HCW'(r_r) + HCW'(1)) >= eff_h_r);
  assign job_a    = r_ge1 && c_ge1;
  assign job_b    = r_ge1 && end_row;
  assign d_end    = ((WCW'(d_r) + WCW'(1)) >= eff_w_r);
  assign dn2_vld  = ((WCW'(d_r) + WCW'(1)) < eff_w_r);
  assign top_px   = r_ge2 ? rd_two_r : '0;
  assign mid_px   = r_ge1 ? rd_one_r : '0;
  assign new_col  = {px_r, mid_px, top_px};
  assign mem_we   = (state_r == sem_pkg::T_PXRD);

  always_comb begin
    if (state_r == sem_pkg::T_IDLE) begin
      rd_addr = in_action ? (d_r - AW'(1)) : c_r;
    end else begin
      rd_addr = d_r + AW'(dk_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_one[c_r] <= px_r;
      mem_two[c_r] <= rd_one_r;
    end
    rd_one_r <= mem_one[rd_addr];
    rd_two_r <= mem_two[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == sem_pkg::T_IDLE);
    case (state_r)
      sem_pkg::T_IDLE: begin
        if (in_valid) begin
          if (!in_action && !draining_r) state_nxt = sem_pkg::T_PXRD;
          else if (in_action && draining_r) state_nxt = sem_pkg::T_DRRD;
        end
      end
      sem_pkg::T_PXRD: state_nxt = (job_a || job_b) ? sem_pkg::T_MAG : sem_pkg::T_IDLE;
      sem_pkg::T_DRRD: if (dk_r == 2'd2) state_nxt = sem_pkg::T_MAG;
      sem_pkg::T_MAG:  if (mag_done) state_nxt = sem_pkg::T_OUT;
      sem_pkg::T_OUT: begin
        if (out_load) state_nxt = jobb_r ? sem_pkg::T_MAG : sem_pkg::T_IDLE;
      end
      default: state_nxt = sem_pkg::T_IDLE;
    endcase
    if (cfg_we) state_nxt = sem_pkg::T_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sem_pkg::T_IDLE;
      eff_w_r     <= WCW'(sem_pkg::clamp_dim(sem_pkg::RESET_WIDTH, MAX_WIDTH));
      eff_h_r     <= HCW'(sem_pkg::clamp_dim(sem_pkg::RESET_HEIGHT, MAX_HEIGHT));
      c_r         <= '0;
      r_r         <= '0;
      d_r         <= '0;
      draining_r  <= 1'b0;
      wc_r        <= '0;
      jobb_r      <= 1'b0;
      start_r     <= 1'b0;
      dk_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH) begin
          eff_w_r <= WCW'(sem_pkg::clamp_dim(32'(cfg_data[10:0]), MAX_WIDTH));
        end
        if (cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) begin
          eff_h_r <= HCW'(sem_pkg::clamp_dim(32'(cfg_data), MAX_HEIGHT));
        end
        if (cfg_index == sem_pkg::CFG_IMAGE_WIDTH || cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) begin
          c_r        <= '0;
          r_r        <= '0;
          d_r        <= '0;
          draining_r <= 1'b0;
          wc_r       <= '0;
        end
        jobb_r <= 1'b0;
      end else begin
        case (state_r)
          sem_pkg::T_IDLE: begin
            if (accept) begin
              dk_r   <= 2'd0;
              rvld_r <= (d_r != '0);
            end
          end
          sem_pkg::T_PXRD: begin
            start_r <= job_a || job_b;
            jobb_r  <= job_a && job_b;
            if (end_row) begin
              wc_r <= '0;
              c_r  <= '0;
              if (last_row) begin
                draining_r <= 1'b1;
                d_r        <= '0;
                r_r        <= '0;
              end else begin
                r_r <= r_r + RW'(1);
              end
            end else begin
              wc_r <= {new_col, wc_r[1]};
              c_r  <= c_r + AW'(1);
            end
          end
          sem_pkg::T_DRRD: begin
            if (dk_r == 2'd2) begin
              start_r <= 1'b1;
              jobb_r  <= 1'b0;
              if (d_end) begin
                draining_r <= 1'b0;
                d_r        <= '0;
                r_r        <= '0;
                c_r        <= '0;
              end else begin
                d_r <= d_r + AW'(1);
              end
            end else begin
              dk_r   <= dk_r + 2'd1;
              rvld_r <= (dk_r == 2'd0) ? 1'b1 : dn2_vld;
            end
          end
          sem_pkg::T_OUT: begin
            if (out_load && jobb_r) begin
              jobb_r  <= 1'b0;
              start_r <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      sem_pkg::T_IDLE: begin
        if (accept) px_r <= {in_pixel_blue, in_pixel_green, in_pixel_red};
      end
      sem_pkg::T_PXRD: begin
        res_row_r <= 12'(32'(r_r) - 32'd1);
        res_eof_r <= 1'b0;
        if (job_a) begin
          g_r        <= {new_col, wc_r[1], wc_r[0]};
          res_col_r  <= 10'(32'(c_r) - 32'd1);
          res_last_r <= !job_b;
        end else begin
          g_r        <= {sem_pkg::col_t'('0), new_col, wc_r[1]};
          res_col_r  <= 10'(c_r);
          res_last_r <= 1'b1;
        end
      end
      sem_pkg::T_DRRD: begin
        g_r[dk_r] <= rvld_r ? {sem_pkg::pix_t'('0), rd_one_r, (h_ge2 ? rd_two_r : '0)} : '0;
        if (dk_r == 2'd2) begin
          res_row_r  <= 12'(32'(eff_h_r) - 32'd1);
          res_col_r  <= 10'(d_r);
          res_last_r <= 1'b1;
          res_eof_r  <= d_end;
        end
      end
      sem_pkg::T_OUT: begin
        if (out_load) begin
          out_mag_r  <= mag;
          out_row_r  <= res_row_r;
          out_col_r  <= res_col_r;
          out_last_r <= res_last_r;
          out_eof_r  <= res_eof_r;
          if (jobb_r) begin
            g_r        <= {sem_pkg::col_t'('0), g_r[2], g_r[1]};
            res_col_r  <= res_col_r + 10'd1;
            res_last_r <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  sem_mag u_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .win   (g_r),
    .done  (mag_done),
    .mag   (mag)
  );

  assign out_valid        = out_valid_r;
  assign out_edge_red     = out_mag_r[0];
  assign out_edge_green   = out_mag_r[1];
  assign out_edge_blue    = out_mag_r[2];
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_last_in_run  = out_last_r;
  assign out_end_of_frame = out_eof_r;

  a_drain_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (c_r == '0))
    else $error("column counter nonzero while draining");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    32'(c_r) < 32'(eff_w_r))
    else $error("column counter beyond frame width");

  a_second_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    jobb_r |-> !res_last_r)
    else $error("first of two results flagged last");

endmodule

`default_nettype wire
